FILE: rtl/newton_square_root_defines.svh
// Assertion macros for the newton_square_root checker.
// No dependencies; included by files that assert.
`ifndef NEWTON_SQUARE_ROOT_DEFINES_SVH
`define NEWTON_SQUARE_ROOT_DEFINES_SVH

// Same-cycle implication, ignored while in reset.
`define NSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while in reset.
`define NSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define NSR_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/nsr_pkg.sv
// Shared constants and stage types for the Newton square root pipeline.
// No dependencies.
package nsr_pkg;

  localparam int WIDTH      = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ITERATIONS = 10;
  // Dividend width: radicand shifted up by the fraction bits.
  localparam int NUM_W      = WIDTH + FRAC_BITS;
  // Depth of one iteration: the divider stages plus the update stage.
  localparam int ITER_LAT   = NUM_W + 1;

  localparam logic [WIDTH-1:0] EST_INIT = WIDTH'(1) << FRAC_BITS;

  // Item between iterations.
  typedef struct packed {
    logic             valid;
    logic [WIDTH-1:0] rad;
    logic [WIDTH-1:0] est;
  } iter_t;

  // Item inside the divider.
  typedef struct packed {
    logic             valid;
    logic [WIDTH-1:0] rad;
    logic [WIDTH-1:0] est;
    logic [WIDTH-1:0] rem;
    logic [NUM_W-1:0] work;
  } div_t;

endpackage

FILE: rtl/nsr_if.sv
// Stream interfaces for the radicand and root channels.
// Depends on nsr_pkg.
interface nsr_radicand_if import nsr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] radicand;
  modport source (output valid, output radicand, input ready);
  modport sink (input valid, input radicand, output ready);
endinterface

interface nsr_root_if import nsr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] root_estimate;
  modport source (output valid, output root_estimate, input ready);
  modport sink (input valid, input root_estimate, output ready);
endinterface

FILE: rtl/nsr_iter.sv
// One Newton step: pipelined restoring divide, one quotient bit per stage,
// then the averaging stage. Depends on nsr_pkg.
module nsr_iter import nsr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  iter_t src,
  output iter_t dst
);

  div_t pipe [NUM_W];
  div_t head;

  always_comb begin
    head.valid = src.valid;
    head.rad   = src.rad;
    head.est   = src.est;
    head.rem   = '0;
    head.work  = {src.rad, {FRAC_BITS{1'b0}}};
  end

  for (genvar i = 0; i < NUM_W; i++) begin : g_div
    div_t          prev;
    logic [WIDTH:0] trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign prev = head;
    end else begin : g_rest
      assign prev = pipe[i-1];
    end

    assign trial = {prev.rem, prev.work[NUM_W-1]};
    assign ge    = trial >= {1'b0, prev.est};

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[i].valid <= 1'b0;
      end else if (en) begin
        pipe[i].valid <= prev.valid;
      end
      if (en) begin
        pipe[i].rad  <= prev.rad;
        pipe[i].est  <= prev.est;
        pipe[i].rem  <= ge ? WIDTH'(trial - {1'b0, prev.est}) : trial[WIDTH-1:0];
        pipe[i].work <= {prev.work[NUM_W-2:0], ge};
      end
    end
  end

  // Averaging stage; a zero estimate takes a zero quotient.
  logic [NUM_W-1:0] q;
  logic [NUM_W:0]   sum;
  logic [NUM_W-1:0] half;
  logic [WIDTH-1:0] est_next;

  always_comb begin
    q        = (pipe[NUM_W-1].est == '0) ? '0 : pipe[NUM_W-1].work;
    sum      = {{(FRAC_BITS+1){1'b0}}, pipe[NUM_W-1].est} + {1'b0, q};
    half     = sum[NUM_W:1];
    est_next = (half[NUM_W-1:WIDTH] != '0) ? '1 : half[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst.valid <= 1'b0;
    end else if (en) begin
      dst.valid <= pipe[NUM_W-1].valid;
    end
    if (en) begin
      dst.rad <= pipe[NUM_W-1].rad;
      dst.est <= est_next;
    end
  end

endmodule

FILE: rtl/newton_square_root.sv
// Newton square root: radicand in Q16.16 in, root estimate in Q16.16 out.
// Channel req carries radicand, channel rsp carries root_estimate; both are
// valid/ready streams, an item moves when valid and ready are both high.
// The estimate starts at 1.0 and takes ten Heron steps
// est = (est + rad/est) / 2, each division truncating.
// Each step is a 48-stage restoring divider (one quotient bit per stage)
// plus one averaging stage; all ten steps are registered in series between
// acceptance and rsp.valid. One item is taken every cycle while rsp drains.
// The last stage is the output register. When rsp stalls with a result
// waiting, the whole pipeline holds and req.ready drops; nothing is lost or
// repeated. req.ready is high whenever the output register is empty or
// being taken.
// Synchronous reset clears all valid bits; the pipeline is empty after it.
// Depends on nsr_pkg, nsr_if, nsr_iter.
module newton_square_root import nsr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  nsr_radicand_if.sink         req,
  nsr_root_if.source           rsp
);

  iter_t chain [ITERATIONS+1];
  logic  en;

  assign en = !chain[ITERATIONS].valid || rsp.ready;
  assign req.ready = en;

  always_comb begin
    chain[0].valid = req.valid;
    chain[0].rad   = req.radicand;
    chain[0].est   = EST_INIT;
  end

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
    nsr_iter u_iter (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .src (chain[k]),
      .dst (chain[k+1])
    );
  end

  assign rsp.valid         = chain[ITERATIONS].valid;
  assign rsp.root_estimate = chain[ITERATIONS].est;

endmodule

FILE: rtl/nsr_checker.sv
// Port-level checks for newton_square_root, bound to the top level.
// Depends on nsr_pkg and newton_square_root_defines.svh.
`include "newton_square_root_defines.svh"

module nsr_checker import nsr_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WIDTH-1:0] out_root
);

  `NSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_root), "result changed while stalled")
  `NSR_ASSERT_NOW(a_ready_map, 1'b1, in_ready == (!out_valid || out_ready), "input ready does not follow output backpressure")
  `NSR_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid, "result shown right after reset")
  `NSR_ASSERT_NEXT(a_stall_blocks, out_valid && !out_ready && in_valid, !$past(in_ready), "item taken during a stall")

endmodule

bind newton_square_root nsr_checker u_nsr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_root  (rsp.root_estimate)
);

FILE: dv/nsr_tb_if.sv
// Testbench-side note: the stream interfaces come from the RTL (nsr_if.sv).
// This file only holds shared testbench constants; depends on nsr_pkg.
`timescale 1ns / 100ps
package nsr_tb_pkg;
  import nsr_pkg::*;
  // Pipeline depth from acceptance to rsp.valid: iterations times stages per iteration.
  localparam int PIPE_LAT = ITERATIONS * ITER_LAT;
endpackage

FILE: dv/testbench.sv
// Self-checking testbench for newton_square_root: directed table, then random radicands,
// checked in order against known roots or a Heron-step predictor. Depends on nsr_pkg, nsr_if, nsr_tb_pkg.
`timescale 1ns / 100ps
module testbench;
  import nsr_pkg::*;
  import nsr_tb_pkg::*;

  localparam int N_RANDOM = 2000;
  localparam int N_DIRECTED = 12;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst;
  nsr_radicand_if req ();
  nsr_root_if rsp ();

  newton_square_root DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  logic [WIDTH-1:0] root_queue[$];
  int errors = 0;
  int src_idle_pct = 25;
  int snk_idle_pct = 59;
  longint cycles = 0;

  // Heron iteration, truncating, with a 32-bit saturation guard.
  function automatic logic [WIDTH-1:0] heron_root(logic [WIDTH-1:0] rad);
    logic [63:0] num;
    logic [63:0] est;
    logic [63:0] q;
    logic [63:0] nxt;
    num = 64'(rad) << FRAC_BITS;
    est = 64'(EST_INIT);
    for (int i = 0; i < ITERATIONS; i++) begin
      q = (est != 0) ? num / est : 64'd0;
      nxt = (est + q) >> 1;
      if (nxt > 64'hFFFF_FFFF) nxt = 64'hFFFF_FFFF;
      est = nxt;
    end
    return est[WIDTH-1:0];
  endfunction

  typedef struct {
    logic [WIDTH-1:0] rad;
    logic             known;
    logic [WIDTH-1:0] root;
  } row_t;

  row_t directed[N_DIRECTED] = '{
    '{32'h0000_0000, 1'b1, 32'h0000_0040},   // zero radicand: 1.0 halved ten times
    '{32'h0001_0000, 1'b1, 32'h0001_0000},   // 1.0 is a fixed point
    '{32'hFFFF_FFFF, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b0, 32'h0},
    '{32'h0004_0000, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 32'h0},
    '{32'h7FFF_FFFF, 1'b0, 32'h0},
    '{32'h5555_5555, 1'b0, 32'h0},
    '{32'hAAAA_AAAA, 1'b0, 32'h0},
    '{32'h0000_FFFF, 1'b0, 32'h0},
    '{32'h0064_0000, 1'b0, 32'h0},
    '{32'hFFFF_0000, 1'b0, 32'h0}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stalls, in-order check.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        if (root_queue.size() == 0) begin
          $error("root_estimate: unexpected item, actual %h", rsp.root_estimate);
          errors++;
        end else begin
          logic [WIDTH-1:0] exp_root;
          exp_root = root_queue.pop_front();
          if (rsp.root_estimate !== exp_root) begin
            $error("root_estimate: expected %h actual %h", exp_root, rsp.root_estimate);
            errors++;
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Leaves valid high after the accepting edge; the next call or the caller drops it.
  task automatic send_radicand(logic [WIDTH-1:0] rad, logic [WIDTH-1:0] exp_root);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.radicand <= rad;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    root_queue.push_back(exp_root);
  endtask

  function automatic logic [WIDTH-1:0] rand_radicand();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'h0001_0000);
      2: return $urandom() >> $urandom_range(31);
      default: return 32'hFFFF_FFFF - $urandom_range(255);
    endcase
  endfunction

  initial begin
    logic [WIDTH-1:0] rad;
    req.valid = 1'b0;
    req.radicand = '0;
    @(negedge rst);
    @(posedge clk);
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_radicand(directed[i].rad,
                    directed[i].known ? directed[i].root : heron_root(directed[i].rad));
    end
    req.valid <= 1'b0;
    // Hold off until the pipeline drains.
    while (root_queue.size() != 0) @(posedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 59 : 0;
      snk_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 25 : 0;
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        rad = rand_radicand();
        send_radicand(rad, heron_root(rad));
      end
    end
    req.valid <= 1'b0;
    while (root_queue.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 20) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
